>>> hdl/scfp_pkg.sv
// Shared types, constants and the checksum helper for the coordinate frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

  localparam logic [7:0] HdrByte = 8'hFF;
  localparam logic [7:0] TrlByte = 8'hFE;
  localparam logic [8:0] ChkMod  = 9'd254;

  // Next frame position expected; hunt means waiting for a header.
  typedef enum logic [6:0] {
    PhHunt = 7'b0000001,
    PhXHi  = 7'b0000010,
    PhXLo  = 7'b0000100,
    PhYHi  = 7'b0001000,
    PhYLo  = 7'b0010000,
    PhChk  = 7'b0100000,
    PhTrl  = 7'b1000000
  } scfp_phase_e;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        target_seen;
    logic        frame_done;
    logic        frame_error;
  } scfp_result_t;

  // (x + y) mod 254 with 256 == 2 (mod 254): fold the high bytes twice,
  // then one conditional subtract.
  function automatic logic [7:0] chk_mod(input logic [7:0] xh, input logic [7:0] xl,
                                         input logic [7:0] yh, input logic [7:0] yl);
    logic [10:0] s1;
    logic [8:0]  s2;
    s1 = ({3'b000, xh} << 1) + ({3'b000, yh} << 1) + {3'b000, xl} + {3'b000, yl};
    s2 = {5'b00000, s1[10:8], 1'b0} + {1'b0, s1[7:0]};
    if (s2 >= ChkMod) begin
      chk_mod = 8'(s2 - ChkMod);
    end else begin
      chk_mod = s2[7:0];
    end
  endfunction

endpackage

>>> hdl/scfp_parser.sv
// Frame parser: phase state machine, held bytes, checksum and latched coordinates.
`timescale 1ns / 1ps

module scfp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output scfp_pkg::scfp_result_t result_o
);

  scfp_pkg::scfp_phase_e phase_q, phase_d, ph_nxt;
  logic [7:0]  held_q [4];
  logic [7:0]  held_d [4];
  logic [7:0]  check_q, check_d;
  logic [15:0] lat_x_q, lat_x_d;
  logic [15:0] lat_y_q, lat_y_d;
  logic        tgt_q, tgt_d;
  logic        fit, done, err;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    check_d = check_q;
    lat_x_d = lat_x_q;
    lat_y_d = lat_y_q;
    tgt_d   = tgt_q;
    fit     = 1'b0;
    done    = 1'b0;
    err     = 1'b0;
    ph_nxt  = scfp_pkg::PhHunt;
    case (phase_q)
      scfp_pkg::PhHunt: begin
        fit    = (byte_i == scfp_pkg::HdrByte);
        ph_nxt = scfp_pkg::PhXHi;
      end
      scfp_pkg::PhXHi: begin
        if (byte_i != scfp_pkg::HdrByte) begin
          held_d[0] = byte_i;
          fit       = 1'b1;
        end
        ph_nxt = scfp_pkg::PhXLo;
      end
      scfp_pkg::PhXLo: begin
        held_d[1] = byte_i;
        tgt_d     = (byte_i != 8'h00);
        fit       = 1'b1;
        ph_nxt    = scfp_pkg::PhYHi;
      end
      scfp_pkg::PhYHi: begin
        if (byte_i != scfp_pkg::HdrByte) begin
          held_d[2] = byte_i;
          fit       = 1'b1;
        end
        ph_nxt = scfp_pkg::PhYLo;
      end
      scfp_pkg::PhYLo: begin
        held_d[3] = byte_i;
        check_d   = scfp_pkg::chk_mod(held_q[0], held_q[1], held_q[2], byte_i);
        fit       = 1'b1;
        ph_nxt    = scfp_pkg::PhChk;
      end
      scfp_pkg::PhChk: begin
        fit    = (byte_i == check_q);
        ph_nxt = scfp_pkg::PhTrl;
      end
      scfp_pkg::PhTrl: begin
        if (byte_i == scfp_pkg::TrlByte) begin
          lat_x_d = {held_q[0], held_q[1]};
          lat_y_d = {held_q[2], held_q[3]};
          done    = 1'b1;
          fit     = 1'b1;
        end
        ph_nxt = scfp_pkg::PhHunt;
      end
      default: begin
        fit = 1'b0;
      end
    endcase

    if (done) begin
      phase_d = scfp_pkg::PhHunt;
    end else if (fit) begin
      phase_d = ph_nxt;
    end else begin
      // mismatch: back to hunting, drop target; only an error mid-frame
      err     = (phase_q != scfp_pkg::PhHunt);
      phase_d = scfp_pkg::PhHunt;
      tgt_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= scfp_pkg::PhHunt;
      check_q <= 8'h00;
      lat_x_q <= 16'h0000;
      lat_y_q <= 16'h0000;
      tgt_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      check_q <= check_d;
      lat_x_q <= lat_x_d;
      lat_y_q <= lat_y_d;
      tgt_q   <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      held_q <= held_d;
    end
  end

  assign result_o.pos_x       = lat_x_d;
  assign result_o.pos_y       = lat_y_d;
  assign result_o.target_seen = tgt_d;
  assign result_o.frame_done  = done;
  assign result_o.frame_error = err;

endmodule

>>> hdl/serial_coordinate_frame_parser_core.sv
// Top level: input word register, frame parser and result register.
`timescale 1ns / 1ps

// Serial coordinate frame parser. Each input word is one received byte; the
// block hunts for a seven-byte frame (0xFF header, x high, x low, y high,
// y low, checksum = (x + y) mod 254, 0xFE trailer) and gives exactly one
// result word per byte: the last latched x and y, the target flag (set by a
// nonzero x low byte, cleared by any framing mismatch), frame_done when the
// byte was a valid trailer, and frame_error when the byte broke a frame in
// progress. Throughput is one byte per cycle unless the output stalls; each
// byte passes the input register, then the result register, with the whole
// parse step done in a single pass between them. A stalled result holds the
// result register, and the input register keeps taking a word until it is
// also full, so in_stall_o only rises when both stages hold words.

module serial_coordinate_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic        target_seen_o,
  output logic        frame_done_o,
  output logic        frame_error_o
);

  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             s1_byte_q;
  logic                   out_valid_q, out_valid_d;
  scfp_pkg::scfp_result_t out_q, step_res;
  logic                   out_free, s1_adv, in_acc;

  // result register can take a word when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_adv) begin
      out_q <= step_res;
    end
  end

  // parser state advances only when its word moves into the result register
  scfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .byte_i   (s1_byte_q),
    .result_o (step_res)
  );

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = out_q.pos_x;
  assign pos_y_o       = out_q.pos_y;
  assign target_seen_o = out_q.target_seen;
  assign frame_done_o  = out_q.frame_done;
  assign frame_error_o = out_q.frame_error;

  // a result is either a completed frame or a broken one, never both
  a_done_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_done_o && frame_error_o))
    else $error("frame_done and frame_error both set");

  // a completed frame reports its own x, whose high byte is never 0xFF
  a_done_xhi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (pos_x_o[15:8] != scfp_pkg::HdrByte))
    else $error("completed frame with x high byte 0xFF");

  // a word leaving the input register always lands in the result register
  a_adv_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced word lost");

  // input stall only while the input register holds a word and the output is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

endmodule

>>> sim/serial_coordinate_frame_parser_core_tb.sv
// Testbench for the coordinate frame parser: directed and random traffic with a parse predictor.
`timescale 1ns / 1ps

module serial_coordinate_frame_parser_core_tb;

  localparam int unsigned FrameBytesTarget = 1700;
  localparam int unsigned DrainEvery       = 400;
  localparam int unsigned IdleLimit        = 4000;
  localparam int unsigned TailCycles       = 8;

  // Frame positions that a broken frame can be corrupted at.
  localparam int unsigned BreakNone = 0;
  localparam int unsigned BreakXHi  = 1;
  localparam int unsigned BreakYHi  = 3;
  localparam int unsigned BreakChk  = 5;
  localparam int unsigned BreakTrl  = 6;

  typedef struct {
    logic [7:0] b;
    bit         drain;  // hold this word back until all results are in
  } rx_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [15:0] pos_x_o;
  logic [15:0] pos_y_o;
  logic        target_seen_o;
  logic        frame_done_o;
  logic        frame_error_o;

  rx_word_t               rx_bytes_q[$];
  scfp_pkg::scfp_result_t coord_status_q[$];
  int unsigned            mismatches = 0;
  bit                     drain_next = 1'b0;

  // Predictor state.
  scfp_pkg::scfp_phase_e ph = scfp_pkg::PhHunt;
  logic [7:0]            held[4];
  logic [7:0]            chk_want = 8'h00;
  logic [15:0]           lat_x = 16'h0000;
  logic [15:0]           lat_y = 16'h0000;
  logic                  tgt = 1'b0;

  serial_coordinate_frame_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .target_seen_o (target_seen_o),
    .frame_done_o  (frame_done_o),
    .frame_error_o (frame_error_o)
  );

  always #4 clk_i = ~clk_i;

  // Steps the parser by one byte and queues the result word it must give.
  task automatic parse_rx_byte(input logic [7:0] b);
    logic                   fit;
    logic                   done;
    logic                   err;
    int unsigned            xv;
    int unsigned            yv;
    scfp_pkg::scfp_result_t r;
    fit  = 1'b0;
    done = 1'b0;
    xv   = {16'h0000, held[0], held[1]};
    yv   = {16'h0000, held[2], b};
    case (ph)
      scfp_pkg::PhHunt: fit = (b == scfp_pkg::HdrByte);
      scfp_pkg::PhXHi: begin
        if (b < scfp_pkg::HdrByte) begin
          held[0] = b;
          fit = 1'b1;
        end
      end
      scfp_pkg::PhXLo: begin
        held[1] = b;
        tgt = (b != 8'h00);
        fit = 1'b1;
      end
      scfp_pkg::PhYHi: begin
        if (b < scfp_pkg::HdrByte) begin
          held[2] = b;
          fit = 1'b1;
        end
      end
      scfp_pkg::PhYLo: begin
        held[3] = b;
        chk_want = 8'((xv + yv) % 254);
        fit = 1'b1;
      end
      scfp_pkg::PhChk: fit = (b == chk_want);
      scfp_pkg::PhTrl: begin
        if (b == scfp_pkg::TrlByte) begin
          lat_x = {held[0], held[1]};
          lat_y = {held[2], held[3]};
          done = 1'b1;
          fit = 1'b1;
        end
      end
      default: ;
    endcase
    // A mismatch while hunting is silent; inside a frame it flags an error.
    err = !fit && (ph != scfp_pkg::PhHunt);
    if (done || !fit) begin
      ph = scfp_pkg::PhHunt;
      if (!fit) tgt = 1'b0;
    end else begin
      case (ph)
        scfp_pkg::PhHunt: ph = scfp_pkg::PhXHi;
        scfp_pkg::PhXHi:  ph = scfp_pkg::PhXLo;
        scfp_pkg::PhXLo:  ph = scfp_pkg::PhYHi;
        scfp_pkg::PhYHi:  ph = scfp_pkg::PhYLo;
        scfp_pkg::PhYLo:  ph = scfp_pkg::PhChk;
        scfp_pkg::PhChk:  ph = scfp_pkg::PhTrl;
        default:          ph = scfp_pkg::PhHunt;
      endcase
    end
    r.pos_x       = lat_x;
    r.pos_y       = lat_y;
    r.target_seen = tgt;
    r.frame_done  = done;
    r.frame_error = err;
    coord_status_q.push_back(r);
  endtask

  task automatic add_byte(input logic [7:0] b);
    rx_word_t w;
    w.b = b;
    w.drain = drain_next;
    drain_next = 1'b0;
    rx_bytes_q.push_back(w);
  endtask

  // Queues one frame; a nonzero break position corrupts that byte and ends the frame.
  task automatic add_frame(input logic [7:0] xh, input logic [7:0] xl,
                           input logic [7:0] yh, input logic [7:0] yl,
                           input int unsigned break_at);
    int unsigned sum;
    logic [7:0]  chk;
    sum = {16'h0000, xh, xl} + {16'h0000, yh, yl};
    chk = 8'(sum % 254);
    add_byte(scfp_pkg::HdrByte);
    if (break_at == BreakXHi) begin
      add_byte(scfp_pkg::HdrByte);
      return;
    end
    add_byte(xh);
    add_byte(xl);
    if (break_at == BreakYHi) begin
      add_byte(scfp_pkg::HdrByte);
      return;
    end
    add_byte(yh);
    add_byte(yl);
    if (break_at == BreakChk) begin
      add_byte(chk ^ 8'($urandom_range(1, 255)));
      return;
    end
    add_byte(chk);
    if (break_at == BreakTrl) begin
      add_byte(scfp_pkg::TrlByte ^ 8'($urandom_range(1, 255)));
      return;
    end
    add_byte(scfp_pkg::TrlByte);
  endtask

  function automatic logic [7:0] pick_high();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFE;
      default: return 8'($urandom_range(0, 254));
    endcase
  endfunction

  function automatic logic [7:0] pick_low();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: bursts of words with random gaps, plus drain pauses on marked words.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    rx_word_t w;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
    end else begin
      if (in_valid && !in_stall_o) parse_rx_byte(rx_byte);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_bytes_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (rx_bytes_q[0].drain && coord_status_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          w = rx_bytes_q.pop_front();
          rx_byte  <= w.b;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // Receiver: stall pattern changes by segment, some segments never stall.
  int unsigned seg_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk_i) begin
    scfp_pkg::scfp_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (coord_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result word with none expected: x=%h y=%h t=%b d=%b e=%b",
                     pos_x_o, pos_y_o, target_seen_o, frame_done_o, frame_error_o);
        end else begin
          want = coord_status_q.pop_front();
          if (pos_x_o !== want.pos_x || pos_y_o !== want.pos_y ||
              target_seen_o !== want.target_seen || frame_done_o !== want.frame_done ||
              frame_error_o !== want.frame_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp x=%h y=%h t=%b d=%b e=%b, got x=%h y=%h t=%b d=%b e=%b",
                       want.pos_x, want.pos_y, want.target_seen, want.frame_done,
                       want.frame_error, pos_x_o, pos_y_o, target_seen_o,
                       frame_done_o, frame_error_o);
          end
        end
      end
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left   = $urandom_range(10, 150);
      end else begin
        seg_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  // Watchdog: cycles with no word moving on either side.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned frame_bytes;
    int unsigned next_drain;
    int unsigned pick;
    int unsigned brk;
    int unsigned noise;

    // Directed: hunt noise, extreme frame, FF in x high (not a new header),
    // wrong trailer, FF in y high, bad checksum.
    add_byte(8'h00);
    add_byte(8'hFE);
    add_frame(8'hFE, 8'hFF, 8'hFE, 8'hFF, BreakNone);
    add_byte(scfp_pkg::HdrByte);
    add_byte(scfp_pkg::HdrByte);
    add_frame(8'h00, 8'h00, 8'h00, 8'h00, BreakTrl);
    add_frame(8'h12, 8'h34, 8'h00, 8'h00, BreakYHi);
    add_frame(8'h01, 8'h02, 8'h03, 8'h04, BreakChk);

    // Random: mostly well-formed frames, some broken ones and line noise.
    frame_bytes = 0;
    next_drain  = 0;
    while (frame_bytes < FrameBytesTarget) begin
      if (frame_bytes >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DrainEvery;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_frame(pick_high(), pick_low(), pick_high(), pick_low(), BreakNone);
        frame_bytes += 7;
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       brk = BreakXHi;
          1:       brk = BreakYHi;
          2:       brk = BreakChk;
          default: brk = BreakTrl;
        endcase
        add_frame(pick_high(), pick_low(), pick_high(), pick_low(), brk);
        frame_bytes += brk + 1;
      end else begin
        noise = $urandom_range(1, 4);
        repeat (noise) add_byte(8'($urandom_range(0, 255)));
        frame_bytes += noise;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything sent and every expected word received, then a short tail.
    while (rx_bytes_q.size() != 0 || in_valid || coord_status_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && coord_status_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/scfp_pkg.sv
hdl/scfp_parser.sv
hdl/serial_coordinate_frame_parser_core.sv
sim/serial_coordinate_frame_parser_core_tb.sv
